@@ design/stsg_pkg.sv @@
// Shared types and constants for the spectrum trace span generator.
// Used by the lane, merge and top-level modules; depends on nothing.
package stsg_pkg;

    // APB register map: register i at byte address 4*i
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_TRACE_LEFT    = 3'd0;
    localparam logic [2:0] REG_TRACE_TOP     = 3'd1;
    localparam logic [2:0] REG_TRACE_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd3;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd4;

    // Palette indexes for the two span kinds
    localparam logic [3:0] COLOUR_ERASE = 4'd0;
    localparam logic [3:0] COLOUR_DRAW  = 4'd3;

    // Smoothing window, Q8 weights: centre 128 (a shift by 7), near 46, far 18
    localparam int unsigned SUM_W    = 26;
    localparam int unsigned W_CTR_SH = 7;
    localparam logic signed [SUM_W-1:0] W_NEAR = 26'sd46;
    localparam logic signed [SUM_W-1:0] W_FAR  = 26'sd18;

    // Input word: one spectrum bin
    typedef struct packed {
        logic signed [15:0] new_magnitude;
        logic signed [15:0] old_magnitude;
        logic               sweep_start;
    } t_in_word;

    // Output word: one vertical span
    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row_start;
        logic [12:0] span_length;
        logic [3:0]  colour;
        logic        last;
    } t_out_word;

    // Configuration seen by each lane
    typedef struct packed {
        logic [11:0] top;
        logic [12:0] hm1;
        logic [12:0] scr_h;
    } t_lane_cfg;

    // Pipeline control driven by the top level into both lanes
    typedef struct packed {
        logic shift;
        logic load1;
        logic load2;
        logic load3;
        logic commit;
        logic first;
    } t_lane_ctl;

    // Span found by one lane
    typedef struct packed {
        logic        keep;
        logic [11:0] start;
        logic [12:0] len;
    } t_lane_span;

endpackage

@@ design/stsg_lane.sv @@
// One trace lane: sample window, 5-tap smoothing, row mapping and span rule.
// Depends on stsg_pkg; two copies run side by side (old and new trace).
module stsg_lane
    import stsg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lane_ctl          i_ctl,
    input  logic signed [15:0] i_sample,
    input  t_lane_cfg          i_cfg,
    output t_lane_span         o_span
);

    logic signed [15:0] r_win [4];
    logic signed [15:0] r_c;
    logic signed [16:0] r_p1;
    logic signed [16:0] r_p2;
    logic signed [15:0] r_y;
    logic [13:0]        r_row;
    logic [13:0]        r_prev;

    logic signed [SUM_W-1:0] w_sum;
    logic [12:0]             w_val;
    logic [13:0]             w_prev_eff;
    logic signed [14:0]      w_diff;
    logic [13:0]             w_start;
    logic [13:0]             w_len;
    logic [14:0]             w_end;

    // Shift the window on each accepted word; index 0 is the latest sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_ctl.shift) begin
            r_win[0] <= i_sample;
            r_win[1] <= r_win[0];
            r_win[2] <= r_win[1];
            r_win[3] <= r_win[2];
        end
    end

    // Stage 1: centre tap and pair sums of symmetric taps
    always_ff @(posedge i_clk) begin
        if (i_ctl.load1) begin
            r_c  <= r_win[1];
            r_p1 <= 17'(r_win[0]) + 17'(r_win[2]);
            r_p2 <= 17'(i_sample) + 17'(r_win[3]);
        end
    end

    // Stage 2: weighted sum, floor divide by 256
    assign w_sum = (SUM_W'(r_c) <<< W_CTR_SH) + SUM_W'(r_p1) * W_NEAR + SUM_W'(r_p2) * W_FAR;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load2) begin
            r_y <= w_sum[23:8];
        end
    end

    // Stage 3: clamp to the trace area and flip into a screen row
    always_comb begin
        if (r_y < 16'sd0) begin
            w_val = '0;
        end else if (r_y > signed'({3'b000, i_cfg.hm1})) begin
            w_val = i_cfg.hm1;
        end else begin
            w_val = r_y[12:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load3) begin
            r_row <= 14'(i_cfg.top) + 14'(i_cfg.hm1) - 14'(w_val);
        end
    end

    // Span joining the previous row to this one, checked and clipped to the screen
    always_comb begin
        w_prev_eff = i_ctl.first ? r_row : r_prev;
        w_diff     = signed'({1'b0, r_row}) - signed'({1'b0, w_prev_eff});
        priority if (w_diff > 15'sd1) begin
            w_start = w_prev_eff + 14'd1;
            w_len   = w_diff[13:0];
        end else if (w_diff < -15'sd1) begin
            w_start = r_row;
            w_len   = 14'(-w_diff);
        end else begin
            w_start = r_row;
            w_len   = 14'd1;
        end
        w_end       = 15'(w_start) + 15'(w_len);
        o_span.keep  = (w_start < 14'(i_cfg.scr_h)) && (w_start[13:12] == 2'b00);
        o_span.start = w_start[11:0];
        if (w_end > 15'(i_cfg.scr_h)) begin
            o_span.len = 13'(14'(i_cfg.scr_h) - w_start);
        end else begin
            o_span.len = w_len[12:0];
        end
    end

    // Hold the row of the last centre column handed to the merge stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_ctl.commit) begin
            r_prev <= r_row;
        end
    end

endmodule

@@ design/stsg_merge.sv @@
// Merge stage: takes the erase and draw spans of one column and sends them
// out one word per cycle while the output is ready, erase first. Depends on stsg_pkg.
module stsg_merge
    import stsg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_lane_span i_old_span,
    input  t_lane_span i_new_span,
    input  logic [11:0] i_column,
    input  logic       i_col_ok,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_word  o_word
);

    logic [1:0]  r_pend;
    logic [1:0]  n_pend;
    t_lane_span  r_old;
    t_lane_span  r_new;
    logic [11:0] r_col;
    logic        r_out_valid;
    logic        n_out_valid;
    t_out_word   r_out;
    t_out_word   n_out;

    logic       w_out_free;
    logic       w_take;
    logic       w_load;
    logic [1:0] w_pend_after;

    // Pick the next pending span; erase goes before draw
    always_comb begin
        w_out_free   = !r_out_valid || i_ready;
        w_take       = w_out_free && (r_pend != 2'b00);
        w_pend_after = r_pend;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        if (w_take) begin
            n_out_valid    = 1'b1;
            n_out.column   = r_col;
            if (r_pend[0]) begin
                w_pend_after      = {r_pend[1], 1'b0};
                n_out.row_start   = r_old.start;
                n_out.span_length = r_old.len;
                n_out.colour      = COLOUR_ERASE;
                n_out.last        = !r_pend[1];
            end else begin
                w_pend_after      = 2'b00;
                n_out.row_start   = r_new.start;
                n_out.span_length = r_new.len;
                n_out.colour      = COLOUR_DRAW;
                n_out.last        = 1'b1;
            end
        end else if (w_out_free) begin
            n_out_valid = 1'b0;
        end
        o_ready = (w_pend_after == 2'b00);
        w_load  = o_ready && i_valid;
    end

    // Load the span flags of a new column, else keep what is still pending
    assign n_pend = w_load ? {i_new_span.keep & i_col_ok, i_old_span.keep & i_col_ok}
                           : w_pend_after;

    // Advance pending flags and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the span pair and the output word
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_load) begin
            r_old <= i_old_span;
            r_new <= i_new_span;
            r_col <= i_column;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule

@@ design/spectrum_trace_span_generator_core.sv @@
// Spectrum trace span generator: two smoothing lanes (old, new) and a merge stage.
// Spans pass the stage 1, 2 and 3 registers, the merge pending flags and the output register;
// the second span word of a bin follows its first. The single output word port slows the flow
// when both spans are drawn; a bin that emits fewer spans frees the merge stage sooner.
// Reset: synchronous active-low i_rst_n clears windows, bin count and rows, and loads
// the register defaults.
module spectrum_trace_span_generator_core
    import stsg_pkg::*;
#(
    parameter int unsigned MAX_BINS = 1024
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_word         o_out_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int unsigned CNT_W = $clog2(MAX_BINS + 1);

    logic [11:0]      r_trace_left;
    logic [11:0]      r_trace_top;
    logic [12:0]      r_trace_height;
    logic [12:0]      r_screen_width;
    logic [12:0]      r_screen_height;
    logic [CNT_W-1:0] r_count;
    logic             r_v1, r_v2, r_v3;
    logic             r_first1, r_first2, r_first3;
    logic [12:0]      r_col1, r_col2, r_col3;

    logic             w_wr;
    logic [2:0]       w_reg_idx;
    logic             w_accept;
    logic [CNT_W-1:0] w_cur;
    logic             w_emit;
    logic             w_first;
    logic [12:0]      w_col;
    logic             w_ready1, w_ready2, w_ready3;
    logic             w_pair_ready;
    logic             w_col_ok;
    t_lane_cfg        w_cfg;
    t_lane_ctl        w_ctl;
    t_lane_span       w_old_span;
    t_lane_span       w_new_span;

    // Configuration port
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ADDR_W-1:2];
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trace_left    <= 12'd0;
            r_trace_top     <= 12'd0;
            r_trace_height  <= 13'd256;
            r_screen_width  <= 13'd1024;
            r_screen_height <= 13'd600;
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_TRACE_LEFT:    r_trace_left    <= pwdata[11:0];
                REG_TRACE_TOP:     r_trace_top     <= pwdata[11:0];
                REG_TRACE_HEIGHT:  r_trace_height  <= pwdata[12:0];
                REG_SCREEN_WIDTH:  r_screen_width  <= pwdata[12:0];
                REG_SCREEN_HEIGHT: r_screen_height <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_TRACE_LEFT:    prdata = 32'(r_trace_left);
            REG_TRACE_TOP:     prdata = 32'(r_trace_top);
            REG_TRACE_HEIGHT:  prdata = 32'(r_trace_height);
            REG_SCREEN_WIDTH:  prdata = 32'(r_screen_width);
            REG_SCREEN_HEIGHT: prdata = 32'(r_screen_height);
            default:           prdata = '0;
        endcase
    end

    // Zero height acts as one row
    assign w_cfg.top   = r_trace_top;
    assign w_cfg.hm1   = (r_trace_height == 13'd0) ? 13'd0 : r_trace_height - 13'd1;
    assign w_cfg.scr_h = r_screen_height;

    // Bin index and whether this bin completes a window
    assign w_accept = i_in_valid && o_in_ready;
    assign w_cur    = i_in_word.sweep_start ? '0 : r_count;
    assign w_emit   = (w_cur >= CNT_W'(4)) && (w_cur <= CNT_W'(MAX_BINS - 1));
    assign w_first  = (w_cur == CNT_W'(4));
    assign w_col    = 13'(w_cur) - 13'd2 + 13'(r_trace_left);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= (w_cur < CNT_W'(MAX_BINS)) ? w_cur + CNT_W'(1) : w_cur;
        end
    end

    // Pipeline handshake; the merge stage back-pressures the whole chain
    assign w_ready3   = !r_v3 || w_pair_ready;
    assign w_ready2   = !r_v2 || w_ready3;
    assign w_ready1   = !r_v1 || w_ready2;
    assign o_in_ready = w_ready1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ready1) r_v1 <= w_accept && w_emit;
            if (w_ready2) r_v2 <= r_v1;
            if (w_ready3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready1) begin
            r_first1 <= w_first;
            r_col1   <= w_col;
        end
        if (w_ready2) begin
            r_first2 <= r_first1;
            r_col2   <= r_col1;
        end
        if (w_ready3) begin
            r_first3 <= r_first2;
            r_col3   <= r_col2;
        end
    end

    assign w_col_ok = (r_col3 < r_screen_width) && !r_col3[12];

    assign w_ctl.shift  = w_accept;
    assign w_ctl.load1  = w_ready1;
    assign w_ctl.load2  = w_ready2;
    assign w_ctl.load3  = w_ready3;
    assign w_ctl.commit = r_v3 && w_pair_ready;
    assign w_ctl.first  = r_first3;

    // Old trace lane (erase spans)
    stsg_lane u_lane_old (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (i_in_word.old_magnitude),
        .i_cfg    (w_cfg),
        .o_span   (w_old_span)
    );

    // New trace lane (draw spans)
    stsg_lane u_lane_new (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (i_in_word.new_magnitude),
        .i_cfg    (w_cfg),
        .o_span   (w_new_span)
    );

    // Merge both lanes into the output word stream
    stsg_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v3),
        .i_old_span (w_old_span),
        .i_new_span (w_new_span),
        .i_column   (r_col3[11:0]),
        .i_col_ok   (w_col_ok),
        .o_ready    (w_pair_ready),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_word     (o_out_word)
    );

    // Only erase and draw colours leave the block
    a_colour_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.colour == COLOUR_ERASE ||
                         o_out_word.colour == COLOUR_DRAW))
        else $error("span word with unknown colour");

    // A draw span always closes its column
    a_draw_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.colour == COLOUR_DRAW) |-> o_out_word.last)
        else $error("draw span without last flag");

    // Clipping never yields an empty span
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.span_length != 13'd0))
        else $error("zero-length span");

    // Stage 1 fills only from an accepted word
    a_v1_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v1) |-> $past(w_accept))
        else $error("pipeline valid without accepted word");

endmodule

@@ test/spectrum_trace_span_checker.sv @@
`timescale 1ns / 100ps
// Span checker for the spectrum trace span generator: watches the bin, span and APB
// channels, predicts every span word and compares it. Depends on stsg_pkg.
module spectrum_trace_span_checker
    import stsg_pkg::*;
#(
    parameter int unsigned MAX_BINS = 1024
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_in_word          i_in_word,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_out_word         i_out_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                o_errors,
    output int                o_pending
);

    // Shadow configuration, tracked from the APB writes
    logic [11:0] left_cfg;
    logic [11:0] top_cfg;
    logic [12:0] height_cfg;
    logic [12:0] width_cfg;
    logic [12:0] scr_height_cfg;

    // Shadow smoothing taps, bin counter and previous rows
    logic signed [15:0] new_taps [4];
    logic signed [15:0] old_taps [4];
    int                 bin_idx;
    int                 last_new_row;
    int                 last_old_row;

    int                 mismatch_count = 0;
    t_out_word          expected_spans [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // Q8 weighted sum of five taps, floored
    function automatic int smooth_q8(input int ctr, input int n1a, input int n1b,
                                     input int n2a, input int n2b);
        int acc;
        acc = 128 * ctr + 46 * (n1a + n1b) + 18 * (n2a + n2b);
        return acc >>> 8;
    endfunction

    // Clamp to the trace area and flip into a screen row
    function automatic int to_screen_row(input int value);
        int h;
        h = (height_cfg == 13'd0) ? 1 : int'(height_cfg);
        if (value > h - 1) value = h - 1;
        if (value < 0) value = 0;
        return int'(top_cfg) + h - 1 - value;
    endfunction

    // Build the span joining prev to row; return 0 when it falls off screen
    function automatic bit make_span(input int col, input int row, input int prev,
                                     input logic [3:0] colour, output t_out_word sp);
        int start;
        int len;
        sp = '0;
        if (row - prev > 1) begin
            start = prev + 1;
            len   = row - prev;
        end else if (row - prev < -1) begin
            start = row;
            len   = prev - row;
        end else begin
            start = row;
            len   = 1;
        end
        if (col >= int'(width_cfg) || col > 4095) return 1'b0;
        if (start < 0 || start >= int'(scr_height_cfg) || start > 4095) return 1'b0;
        // clip at the bottom of the canvas
        if (start + len > int'(scr_height_cfg)) len = int'(scr_height_cfg) - start;
        sp.column      = col[11:0];
        sp.row_start   = start[11:0];
        sp.span_length = len[12:0];
        sp.colour      = colour;
        sp.last        = 1'b0;
        return 1'b1;
    endfunction

    // Advance the shadow state by one bin and queue the spans it causes
    task automatic predict_spans(input t_in_word w);
        int        new_mag;
        int        old_mag;
        int        new_row;
        int        old_row;
        int        col;
        int        cnt;
        int        k;
        t_out_word found [2];
        t_out_word sp;
        new_mag = int'(signed'(w.new_magnitude));
        old_mag = int'(signed'(w.old_magnitude));
        cnt     = 0;
        if (w.sweep_start) bin_idx = 0;

        if (bin_idx >= 4 && bin_idx <= int'(MAX_BINS) - 1) begin
            new_row = to_screen_row(smooth_q8(new_taps[1], new_taps[0], new_taps[2],
                                              new_mag, new_taps[3]));
            old_row = to_screen_row(smooth_q8(old_taps[1], old_taps[0], old_taps[2],
                                              old_mag, old_taps[3]));
            col = bin_idx - 2 + int'(left_cfg);
            // first centre of a sweep: both spans collapse to single pixels
            if (bin_idx == 4) begin
                last_new_row = new_row;
                last_old_row = old_row;
            end
            if (make_span(col, old_row, last_old_row, COLOUR_ERASE, sp)) begin
                found[cnt] = sp;
                cnt++;
            end
            if (make_span(col, new_row, last_new_row, COLOUR_DRAW, sp)) begin
                found[cnt] = sp;
                cnt++;
            end
            last_new_row = new_row;
            last_old_row = old_row;
            if (cnt > 0) found[cnt-1].last = 1'b1;
            for (k = 0; k < cnt; k++) expected_spans.push_back(found[k]);
        end

        // shift the taps and advance the saturating bin counter
        new_taps[3] = new_taps[2];
        new_taps[2] = new_taps[1];
        new_taps[1] = new_taps[0];
        new_taps[0] = w.new_magnitude;
        old_taps[3] = old_taps[2];
        old_taps[2] = old_taps[1];
        old_taps[1] = old_taps[0];
        old_taps[0] = w.old_magnitude;
        if (bin_idx < int'(MAX_BINS)) bin_idx++;
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: span %s mismatch: expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    // Compare one span word with the oldest expectation
    task automatic check_span(input t_out_word got);
        t_out_word want;
        if (expected_spans.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected span word: expected none, actual %h",
                     $time, got);
        end else begin
            want = expected_spans.pop_front();
            compare_field("column", want.column, got.column);
            compare_field("row_start", want.row_start, got.row_start);
            compare_field("span_length", want.span_length, got.span_length);
            compare_field("colour", want.colour, got.colour);
            compare_field("last", want.last, got.last);
        end
    endtask

    // Sample all channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            left_cfg       = 12'd0;
            top_cfg        = 12'd0;
            height_cfg     = 13'd256;
            width_cfg      = 13'd1024;
            scr_height_cfg = 13'd600;
            for (int k = 0; k < 4; k++) begin
                new_taps[k] = '0;
                old_taps[k] = '0;
            end
            bin_idx      = 0;
            last_new_row = 0;
            last_old_row = 0;
            expected_spans.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_TRACE_LEFT:    left_cfg       = pwdata[11:0];
                    REG_TRACE_TOP:     top_cfg        = pwdata[11:0];
                    REG_TRACE_HEIGHT:  height_cfg     = pwdata[12:0];
                    REG_SCREEN_WIDTH:  width_cfg      = pwdata[12:0];
                    REG_SCREEN_HEIGHT: scr_height_cfg = pwdata[12:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) check_span(i_out_word);
            if (i_in_valid && i_in_ready) predict_spans(i_in_word);
        end
        o_pending <= expected_spans.size();
        o_errors  <= mismatch_count;
    end

endmodule

@@ test/spectrum_trace_span_generator_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for spectrum_trace_span_generator_core: drives bins, APB writes and
// output back-pressure, and reports the span checker's verdict. Depends on stsg_pkg.
module spectrum_trace_span_generator_core_tb;
    import stsg_pkg::*;

    localparam int unsigned BINS      = 64;
    localparam int          SETTLE    = 12;
    localparam int          LONG_HOLD = 300;
    localparam int          QUIET_MAX = 3000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              in_valid;
    logic              in_ready;
    t_in_word          in_word;
    logic              out_valid;
    logic              out_ready;
    t_out_word         out_word;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int error_count;
    int pending;
    int idle_odds      = 4;
    bit calm           = 1'b0;
    int stall_requests = 0;
    int stalls_served  = 0;
    int ready_hold     = 0;
    int quiet_cycles   = 0;
    int sweep_left     = 0;
    int cur_height     = 256;
    int new_mag        = 0;
    int old_mag        = 0;

    always #5 i_clk = ~i_clk;

    spectrum_trace_span_generator_core #(.MAX_BINS(BINS)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    spectrum_trace_span_checker #(.MAX_BINS(BINS)) span_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .o_errors    (error_count),
        .o_pending   (pending)
    );

    // Drive output back-pressure: short random bursts, plus one long hold on request
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (ready_hold > 0) begin
                ready_hold--;
                out_ready <= 1'b0;
            end else if (stalls_served < stall_requests) begin
                stalls_served++;
                ready_hold = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end else if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                ready_hold = $urandom_range(0, 8);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Abort when no word moves on any channel for too long
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_MAX) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // APB write: setup cycle, then access until pready
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input int left, input int top, input int height,
                             input int width, input int scr_h);
        write_reg(REG_TRACE_LEFT, left);
        write_reg(REG_TRACE_TOP, top);
        write_reg(REG_TRACE_HEIGHT, height);
        write_reg(REG_SCREEN_WIDTH, width);
        write_reg(REG_SCREEN_HEIGHT, scr_h);
        cur_height = (height == 0) ? 1 : height;
    endtask

    // Pick a setting, leaning on the extremes of each register
    task automatic configure_random();
        int left;
        int top;
        int height;
        int width;
        int scr_h;
        case ($urandom_range(0, 5))
            0:       left = 0;
            1:       left = 4095;
            2:       left = $urandom_range(4000, 4095);
            default: left = $urandom_range(0, 1000);
        endcase
        case ($urandom_range(0, 5))
            0:       top = 0;
            1:       top = 4095;
            default: top = $urandom_range(0, 700);
        endcase
        case ($urandom_range(0, 6))
            0:       height = 0;
            1:       height = 1;
            2:       height = 4096;
            default: height = $urandom_range(2, 700);
        endcase
        case ($urandom_range(0, 5))
            0:       width = 1;
            1:       width = 4096;
            default: width = $urandom_range(16, 1100);
        endcase
        case ($urandom_range(0, 5))
            0:       scr_h = 1;
            1:       scr_h = 4096;
            default: scr_h = top + $urandom_range(0, height + 64);
        endcase
        if (scr_h > 4096) scr_h = 4096;
        if (scr_h < 1) scr_h = 1;
        configure(left, top, height, width, scr_h);
    endtask

    // Offer one bin word, after an optional idle burst, and hold it until taken
    task automatic send_bin(input int nm, input int om, input bit ss);
        t_in_word w;
        if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        w.new_magnitude = nm[15:0];
        w.old_magnitude = om[15:0];
        w.sweep_start   = ss;
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // Wait until every span has come out and the pipe has emptied
    task automatic drain_spans();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Next magnitude: mostly a walk or values inside the trace area, some wild
    function automatic int next_mag(input int prev, input int h);
        case ($urandom_range(0, 9))
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: begin
                case ($urandom_range(0, 3))
                    0:       return -32768;
                    1:       return 32767;
                    2:       return -1;
                    default: return 0;
                endcase
            end
            2, 3, 4, 5: return prev + int'($urandom_range(0, 8)) - 4;
            default: return int'($urandom_range(0, h + 16)) - 8;
        endcase
    endfunction

    // Stream sweeps of random length; a few are cut short or restarted early
    task automatic run_phase(input int count);
        int n;
        bit starting;
        starting = 1'b0;
        for (n = 0; n < count; n++) begin
            if (sweep_left == 0) begin
                case ($urandom_range(0, 9))
                    0:       sweep_left = $urandom_range(1, 4);
                    1, 2:    sweep_left = $urandom_range(BINS - 4, BINS + 20);
                    default: sweep_left = $urandom_range(5, 40);
                endcase
                starting = 1'b1;
            end
            new_mag = next_mag(new_mag, cur_height);
            old_mag = next_mag(old_mag, cur_height);
            send_bin(new_mag, old_mag, starting || ($urandom_range(0, 29) == 0));
            starting = 1'b0;
            sweep_left--;
        end
    endtask

    initial begin
        i_rst_n  <= 1'b0;
        in_valid <= 1'b0;
        in_word  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bins at the reset setting: extremes, clamps, jumps, restart
        send_bin(0, 0, 1'b1);
        send_bin(32767, -32768, 1'b0);
        send_bin(-32768, 32767, 1'b0);
        send_bin(100, 5, 1'b0);
        send_bin(255, 0, 1'b0);
        send_bin(0, 255, 1'b0);
        send_bin(128, 128, 1'b0);
        send_bin(129, 127, 1'b0);
        send_bin(-1, 256, 1'b0);
        send_bin(256, -1, 1'b0);
        send_bin(32767, 32767, 1'b0);
        send_bin(-32768, -32768, 1'b0);
        send_bin(10, 250, 1'b0);
        send_bin(250, 10, 1'b0);
        send_bin(50, 60, 1'b1);
        send_bin(1, 2, 1'b0);
        send_bin(3, 4, 1'b0);
        send_bin(5, 6, 1'b0);
        send_bin(7, 8, 1'b0);
        send_bin(200, 20, 1'b0);
        send_bin(20, 200, 1'b0);
        send_bin(0, 0, 1'b0);
        send_bin(255, 255, 1'b0);
        send_bin(-21846, 21845, 1'b0);
        drain_spans();

        // Zero height collapses the trace to one row
        configure(0, 0, 0, 4096, 4096);
        run_phase(40);
        drain_spans();
        // Columns cross the 4095 limit; a one-row trace on the last screen row
        configure(4040, 4095, 1, 4096, 4096);
        run_phase(40);
        drain_spans();
        // Every span dropped: no words at all
        configure(4095, 3000, 4096, 4096, 4096);
        run_phase(30);
        drain_spans();
        // One-row canvas: only spans starting on row 0 survive, clipped to 1
        configure(0, 0, 4096, 40, 1);
        run_phase(40);
        drain_spans();
        // Canvas bottom cuts through the trace area
        configure(100, 200, 300, 4096, 350);
        run_phase(40);
        drain_spans();

        // Random settings; one phase holds the output off for a long stretch
        for (int p = 0; p < 7; p++) begin
            configure_random();
            idle_odds = (p % 3 == 1) ? 0 : 4;
            if (p == 2) stall_requests++;
            run_phase(100);
            drain_spans();
        end

        // Closing stretch at full rate on both sides
        configure_random();
        calm = 1'b1;
        run_phase(120);
        drain_spans();
        repeat (20) @(posedge i_clk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
